// ===== rtl/core/tcw_pkg.sv =====
// Shared definitions for the text console writer: geometry constants,
// operation and character codes, word types and controller/datapath signals.
// Depends on nothing.
package tcw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int ADDR_W = 11;

    localparam logic [1:0] OP_PUT    = 2'd0;
    localparam logic [1:0] OP_CLEAR  = 2'd1;
    localparam logic [1:0] OP_SETCUR = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;

    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_BLANK     = 8'd32;
    localparam logic [7:0] COLOUR_RESET = 8'h0F;

    typedef struct packed {
        logic [1:0]        op;
        logic [7:0]        char_code;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [ADDR_W-1:0] cell_index;
    } in_word_t;

    typedef struct packed {
        logic [7:0]        cell_char;
        logic [7:0]        cell_attr;
        logic [COL_W-1:0]  cursor_col;
        logic [ROW_W-1:0]  cursor_row;
        logic [ADDR_W-1:0] cursor_linear;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_FILL,
        ST_SCROLL_RD,
        ST_SCROLL,
        ST_BOTTOM,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        WR_ZERO,
        WR_BLANK,
        WR_CELL,
        WR_COPY
    } wr_sel_t;

    typedef enum logic [1:0] {
        RD_INDEX,
        RD_AHEAD,
        RD_AHEAD_NEXT
    } rd_sel_t;

    typedef struct packed {
        logic    load_in;
        logic    exec;
        logic    ptr_clr;
        logic    ptr_inc;
        logic    mem_we;
        wr_sel_t wr_sel;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       newline;
        logic       need_scroll;
        logic       fill_end;
        logic       copy_end;
        logic       out_busy;
    } status_t;

endpackage

// ===== rtl/core/text_console_writer.sv =====
// Top level of the text console writer: joins controller and datapath.
// Depends on tcw_pkg, tcw_ctrl and tcw_datapath.
//
// The block keeps an 80x25 screen of 16-bit cells, attribute byte high and
// character byte low, plus a cursor. Commands arrive as words on the s_
// channel (valid/ready); each command returns exactly one result word on
// the m_ channel, carrying the cursor and, for a read, the cell contents.
// The colour register is written through the cfg_ channel, which is always
// ready; write it only while no command is in flight.
//
// After reset the cell store is swept to zero, one cell per cycle, so
// s_ready stays low until the sweep ends. Cursor, colour (0x0F) and the
// result valid flag are cleared at once.
//
// Commands are processed one at a time. Put (without scroll), set cursor
// and read pass the EXEC state and load the result register in DONE. Clear
// screen adds the FILL sweep and a scrolling put the SCROLL_RD, SCROLL and
// BOTTOM states: both sweep the store through its single write port, one
// cell per cycle, the scroll copying each row up with a one-cell read-ahead.
// The next command is taken in the cycle after the result register loads,
// even if the result is still waiting; if the receiver stalls, a finished
// command holds until the result register frees up.
module text_console_writer
    import tcw_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  in_word_t   s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output out_word_t  m_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);

    // Command and status buses between the sequencer and the datapath.
    cmd_t    cmd;
    status_t status;

    tcw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tcw_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ===== rtl/core/tcw_ctrl.sv =====
// Sequencing controller of the text console writer.
// Depends on tcw_pkg; drives tcw_datapath through cmd_t and reads status_t.
module tcw_ctrl
    import tcw_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT: begin
                if (status.fill_end) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (status.op)
                    OP_PUT:   state_next = status.need_scroll ? ST_SCROLL_RD : ST_DONE;
                    OP_CLEAR: state_next = ST_FILL;
                    default:  state_next = ST_DONE;
                endcase
            end
            ST_FILL: begin
                if (status.fill_end) begin
                    state_next = ST_DONE;
                end
            end
            ST_SCROLL_RD: begin
                state_next = ST_SCROLL;
            end
            ST_SCROLL: begin
                if (status.copy_end) begin
                    state_next = ST_BOTTOM;
                end
            end
            ST_BOTTOM: begin
                if (status.fill_end) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!status.out_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_INIT: begin
                cmd.mem_we  = 1'b1;
                cmd.wr_sel  = WR_ZERO;
                cmd.ptr_inc = !status.fill_end;
                cmd.ptr_clr = status.fill_end;
            end
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.load_in = s_valid;
            end
            ST_EXEC: begin
                cmd.exec    = 1'b1;
                cmd.ptr_clr = 1'b1;
                cmd.wr_sel  = WR_CELL;
                cmd.mem_we  = (status.op == OP_PUT) && !status.newline;
                cmd.rd_sel  = RD_INDEX;
                cmd.rd_en   = (status.op == OP_READ);
            end
            ST_FILL: begin
                cmd.mem_we  = 1'b1;
                cmd.wr_sel  = WR_BLANK;
                cmd.ptr_inc = !status.fill_end;
                cmd.ptr_clr = status.fill_end;
            end
            ST_SCROLL_RD: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_AHEAD;
            end
            ST_SCROLL: begin
                cmd.mem_we  = 1'b1;
                cmd.wr_sel  = WR_COPY;
                cmd.ptr_inc = 1'b1;
                cmd.rd_en   = !status.copy_end;
                cmd.rd_sel  = RD_AHEAD_NEXT;
            end
            ST_BOTTOM: begin
                cmd.mem_we  = 1'b1;
                cmd.wr_sel  = WR_BLANK;
                cmd.ptr_inc = !status.fill_end;
                cmd.ptr_clr = status.fill_end;
            end
            ST_DONE: begin
                cmd.out_load = !status.out_busy;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/core/tcw_datapath.sv =====
// Datapath of the text console writer: cell store, cursor, colour register,
// sweep pointer and result register. Depends on tcw_pkg; commanded by tcw_ctrl.
module tcw_datapath
    import tcw_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  in_word_t   s_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data,
    input  cmd_t       cmd,
    output status_t    status,
    output logic       m_valid,
    input  logic       m_ready,
    output out_word_t  m_data
);

    logic [15:0] cells_mem [CELLS];

    in_word_t          in_reg, in_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [7:0]        colour_reg, colour_next;
    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic [15:0]       rd_data_reg;
    out_word_t         out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    logic [COL_W-1:0]  step_col, clamp_col;
    logic [ROW_W:0]    step_row;
    logic [ROW_W-1:0]  step_row_sat, clamp_row;
    logic              is_nl, is_bs, overflow;
    logic [ADDR_W-1:0] wr_addr, rd_addr, cur_addr, step_addr;
    logic [15:0]       wr_data;
    logic              rd_fire, rd_hit;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                    input logic [COL_W-1:0] c);
        cell_addr = ADDR_W'(ADDR_W'(r) * ADDR_W'(COLUMNS) + ADDR_W'(c));
    endfunction

    assign cfg_ready = 1'b1;

    // Cursor movement of a put, before any scroll.
    always_comb begin
        is_nl    = (in_reg.char_code == CH_NEWLINE);
        is_bs    = (in_reg.char_code == CH_BACKSPACE);
        step_col = col_reg;
        step_row = {1'b0, row_reg};
        if (is_nl) begin
            step_col = '0;
            step_row = {1'b0, row_reg} + 1'b1;
        end else if (is_bs) begin
            if (col_reg != '0) begin
                step_col = col_reg - 1'b1;
            end else if (row_reg != '0) begin
                step_col = COL_W'(COLUMNS - 1);
                step_row = {1'b0, row_reg} - 1'b1;
            end
        end else if (col_reg == COL_W'(COLUMNS - 1)) begin
            step_col = '0;
            step_row = {1'b0, row_reg} + 1'b1;
        end else begin
            step_col = col_reg + 1'b1;
        end
        overflow     = (step_row == (ROW_W + 1)'(ROWS));
        step_row_sat = overflow ? ROW_W'(ROWS - 1) : step_row[ROW_W-1:0];
        clamp_col    = (in_reg.col > COL_W'(COLUMNS - 1)) ? COL_W'(COLUMNS - 1) : in_reg.col;
        clamp_row    = (in_reg.row > ROW_W'(ROWS - 1)) ? ROW_W'(ROWS - 1) : in_reg.row;
    end

    always_comb begin
        cur_addr  = cell_addr(row_reg, col_reg);
        step_addr = cell_addr(step_row[ROW_W-1:0], step_col);
        wr_addr   = ptr_reg;
        wr_data   = '0;
        case (cmd.wr_sel)
            WR_ZERO:  wr_data = '0;
            WR_BLANK: wr_data = {colour_reg, CH_BLANK};
            WR_CELL: begin
                wr_addr = is_bs ? step_addr : cur_addr;
                wr_data = {colour_reg, is_bs ? CH_BLANK : in_reg.char_code};
            end
            WR_COPY:  wr_data = rd_data_reg;
            default:  wr_data = '0;
        endcase
        case (cmd.rd_sel)
            RD_INDEX:      rd_addr = in_reg.cell_index;
            RD_AHEAD:      rd_addr = ptr_reg + ADDR_W'(COLUMNS);
            RD_AHEAD_NEXT: rd_addr = ptr_reg + ADDR_W'(COLUMNS + 1);
            default:       rd_addr = ptr_reg;
        endcase
        rd_fire = cmd.rd_en && (rd_addr < ADDR_W'(CELLS));
    end

    always_ff @(posedge aclk) begin
        if (cmd.mem_we) begin
            cells_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_fire) begin
            rd_data_reg <= cells_mem[rd_addr];
        end
    end

    always_comb begin
        in_next     = cmd.load_in ? s_data : in_reg;
        colour_next = cfg_valid ? cfg_data : colour_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        if (cmd.exec) begin
            case (in_reg.op)
                OP_PUT: begin
                    col_next = step_col;
                    row_next = step_row_sat;
                end
                OP_CLEAR: begin
                    col_next = '0;
                    row_next = '0;
                end
                OP_SETCUR: begin
                    col_next = clamp_col;
                    row_next = clamp_row;
                end
                default: begin
                    col_next = col_reg;
                    row_next = row_reg;
                end
            endcase
        end
        if (cmd.ptr_clr) begin
            ptr_next = '0;
        end else if (cmd.ptr_inc) begin
            ptr_next = ptr_reg + 1'b1;
        end else begin
            ptr_next = ptr_reg;
        end

        rd_hit                 = (in_reg.op == OP_READ) &&
                                 (in_reg.cell_index < ADDR_W'(CELLS));
        out_next               = out_reg;
        out_valid_next         = m_ready ? 1'b0 : out_valid_reg;
        if (cmd.out_load) begin
            out_next.cell_char     = rd_hit ? rd_data_reg[7:0] : 8'd0;
            out_next.cell_attr     = rd_hit ? rd_data_reg[15:8] : 8'd0;
            out_next.cursor_col    = col_reg;
            out_next.cursor_row    = row_reg;
            out_next.cursor_linear = cur_addr;
            out_valid_next         = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg       <= '0;
            row_reg       <= '0;
            colour_reg    <= COLOUR_RESET;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            colour_reg    <= colour_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_reg  <= in_next;
        out_reg <= out_next;
    end

    assign status.op          = in_reg.op;
    assign status.newline     = is_nl;
    assign status.need_scroll = overflow;
    assign status.fill_end    = (ptr_reg == ADDR_W'(CELLS - 1));
    assign status.copy_end    = (ptr_reg == ADDR_W'(CELLS - COLUMNS - 1));
    assign status.out_busy    = out_valid_reg && !m_ready;

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

// ===== rtl/core/tcw_checker.sv =====
// Port-level checks for the text console writer, bound to its top level.
// Depends on tcw_pkg.
module tcw_checker
    import tcw_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_word_t m_data
);

    // The store is being cleared right after reset, so no word is taken.
    a_no_accept_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("input accepted during the reset clearing pass");

    // One command at a time: ready drops right after an acceptance.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second command accepted back to back");

    // The reported cursor is on screen and its linear form agrees.
    a_cursor_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.cursor_col < COL_W'(COLUMNS)) &&
                    (m_data.cursor_row < ROW_W'(ROWS)) &&
                    (m_data.cursor_linear == ADDR_W'(ADDR_W'(m_data.cursor_row) *
                        ADDR_W'(COLUMNS) + ADDR_W'(m_data.cursor_col))))
        else $error("result cursor out of range or inconsistent");

    // A stalled result holds.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled result changed or dropped");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (.*);
